// ----- rtl/vec3_vector_alu_defines.svh -----
// Assertion helpers for the vector unit.
`ifndef VEC3_VECTOR_ALU_DEFINES_SVH
`define VEC3_VECTOR_ALU_DEFINES_SVH

// A condition in the same cycle implies a consequence, outside reset.
`define V3A_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that must hold in the cycle after reset is seen.
`define V3A_AFTER_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

// ----- rtl/v3alu_pkg.sv -----
`timescale 1ns / 1ps
package v3alu_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned TOL_W      = 31;
   localparam logic [TOL_W-1:0] TOL_RESET = 31'd7;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned PROD_W     = 64;
   localparam int unsigned QPROD_W    = PROD_W - FRAC_W;
   localparam int unsigned SUM_W      = 50;
   localparam int unsigned ROOT_STEPS = 32;
   localparam int unsigned QUO_W      = 17;
   localparam int unsigned REM_W      = DATA_W + FRAC_W;
   localparam int unsigned LANES      = 3;
   localparam int unsigned MUL_LANES  = 6;

   typedef enum logic [3:0] {
      KIND_ADD       = 4'd0,
      KIND_SUB       = 4'd1,
      KIND_CROSS     = 4'd2,
      KIND_MULADD    = 4'd3,
      KIND_SCALE     = 4'd4,
      KIND_NEGATE    = 4'd5,
      KIND_DOT       = 4'd6,
      KIND_LENGTH    = 4'd7,
      KIND_NORMALIZE = 4'd8,
      KIND_EXACT_EQ  = 4'd9,
      KIND_APPROX_EQ = 4'd10
   } kind_type;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef struct packed {
      logic [3:0] kind;
      word_type   ax;
      word_type   ay;
      word_type   az;
      word_type   bx;
      word_type   by;
      word_type   bz;
      word_type   factor;
   } req_type;

   typedef struct packed {
      word_type rx;
      word_type ry;
      word_type rz;
      word_type scalar_result;
      logic     equal_flag;
      logic     overflow;
   } rsp_type;

   // Hand-off from the arithmetic front end to the root and divide pipeline.
   typedef struct packed {
      kind_type                     kind;
      logic [LANES-1:0][DATA_W-1:0] avec;
      rsp_type                      res;
      logic [PROD_W-1:0]            sq;
   } mid_type;

   typedef struct packed {
      kind_type                     kind;
      logic [LANES-1:0][DATA_W-1:0] avec;
      rsp_type                      res;
      logic [PROD_W-1:0]            n;
      logic [PROD_W-1:0]            r;
   } root_type;

   typedef struct packed {
      kind_type                     kind;
      logic [LANES-1:0][DATA_W-1:0] avec;
      rsp_type                      res;
      logic [DATA_W-1:0]            len;
      logic [LANES-1:0][REM_W-1:0]  rem;
      logic [LANES-1:0][QUO_W-1:0]  quo;
   } div_type;

   typedef struct packed {
      word_type val;
      logic     ovf;
   } sat_type;

   // Clamp a wide signed value to 32 bits and flag when it did not fit.
   function automatic sat_type sat32(input logic signed [SUM_W-1:0] v);
      sat_type                  s;
      logic [SUM_W-DATA_W:0]    top;
      top = v[SUM_W-1:DATA_W-1];
      if ((&top) || !(|top)) begin
         s.val = v[DATA_W-1:0];
         s.ovf = 1'b0;
      end else begin
         s.val = v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
         s.ovf = 1'b1;
      end
      return s;
   endfunction

endpackage

// ----- rtl/v3alu_arith.sv -----
`timescale 1ns / 1ps
module v3alu_arith (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  v3alu_pkg::req_type            in_req,
   input  logic [v3alu_pkg::TOL_W-1:0]   tol,
   output logic                          out_valid,
   output v3alu_pkg::mid_type            out_mid
);

   v3alu_pkg::req_type  req1_ff;
   logic                v1_ff;
   v3alu_pkg::req_type  req2_ff;
   logic                v2_ff;
   v3alu_pkg::mid_type  mid_ff;
   v3alu_pkg::mid_type  mid_in;
   logic                v3_ff;

   v3alu_pkg::word_type                      opa [v3alu_pkg::MUL_LANES];
   v3alu_pkg::word_type                      opb [v3alu_pkg::MUL_LANES];
   logic signed [v3alu_pkg::PROD_W-1:0]      prod_in [v3alu_pkg::MUL_LANES];
   logic signed [v3alu_pkg::PROD_W-1:0]      prod_ff [v3alu_pkg::MUL_LANES];
   logic signed [v3alu_pkg::QPROD_W-1:0]     qp [v3alu_pkg::MUL_LANES];
   logic signed [v3alu_pkg::SUM_W-1:0]       qe [v3alu_pkg::MUL_LANES];
   logic signed [v3alu_pkg::SUM_W-1:0]       ae [v3alu_pkg::LANES];
   logic signed [v3alu_pkg::SUM_W-1:0]       be [v3alu_pkg::LANES];
   logic signed [v3alu_pkg::SUM_W-1:0]       vsum [v3alu_pkg::LANES];
   logic signed [v3alu_pkg::SUM_W-1:0]       ssum;
   logic signed [v3alu_pkg::SUM_W-1:0]       diff [v3alu_pkg::LANES];
   logic [v3alu_pkg::SUM_W-1:0]              absd [v3alu_pkg::LANES];
   logic [v3alu_pkg::LANES-1:0]              close;
   logic                                     eq;
   v3alu_pkg::sat_type                       vsat [v3alu_pkg::LANES];
   v3alu_pkg::sat_type                       ssat;

   // Operand selection for the six multiplier lanes.
   always_comb begin
      for (int l = 0; l < v3alu_pkg::MUL_LANES; l++) begin
         opa[l] = '0;
         opb[l] = '0;
      end
      unique case (v3alu_pkg::kind_type'(req1_ff.kind))
         v3alu_pkg::KIND_CROSS: begin
            opa[0] = req1_ff.ay; opb[0] = req1_ff.bz;
            opa[1] = req1_ff.az; opb[1] = req1_ff.by;
            opa[2] = req1_ff.az; opb[2] = req1_ff.bx;
            opa[3] = req1_ff.ax; opb[3] = req1_ff.bz;
            opa[4] = req1_ff.ax; opb[4] = req1_ff.by;
            opa[5] = req1_ff.ay; opb[5] = req1_ff.bx;
         end
         v3alu_pkg::KIND_MULADD: begin
            opa[0] = req1_ff.factor; opb[0] = req1_ff.bx;
            opa[1] = req1_ff.factor; opb[1] = req1_ff.by;
            opa[2] = req1_ff.factor; opb[2] = req1_ff.bz;
         end
         v3alu_pkg::KIND_SCALE: begin
            opa[0] = req1_ff.ax; opb[0] = req1_ff.factor;
            opa[1] = req1_ff.ay; opb[1] = req1_ff.factor;
            opa[2] = req1_ff.az; opb[2] = req1_ff.factor;
         end
         v3alu_pkg::KIND_DOT: begin
            opa[0] = req1_ff.ax; opb[0] = req1_ff.bx;
            opa[1] = req1_ff.ay; opb[1] = req1_ff.by;
            opa[2] = req1_ff.az; opb[2] = req1_ff.bz;
         end
         v3alu_pkg::KIND_LENGTH, v3alu_pkg::KIND_NORMALIZE: begin
            opa[0] = req1_ff.ax; opb[0] = req1_ff.ax;
            opa[1] = req1_ff.ay; opb[1] = req1_ff.ay;
            opa[2] = req1_ff.az; opb[2] = req1_ff.az;
         end
         default: begin
         end
      endcase
      for (int l = 0; l < v3alu_pkg::MUL_LANES; l++) begin
         prod_in[l] = v3alu_pkg::PROD_W'(opa[l]) * v3alu_pkg::PROD_W'(opb[l]);
      end
   end

   // Truncated products and sign-extended operands for the combine stage.
   always_comb begin
      for (int l = 0; l < v3alu_pkg::MUL_LANES; l++) begin
         qp[l] = prod_ff[l][v3alu_pkg::PROD_W-1:v3alu_pkg::FRAC_W];
         qe[l] = v3alu_pkg::SUM_W'(qp[l]);
      end
      ae[0] = v3alu_pkg::SUM_W'(req2_ff.ax);
      ae[1] = v3alu_pkg::SUM_W'(req2_ff.ay);
      ae[2] = v3alu_pkg::SUM_W'(req2_ff.az);
      be[0] = v3alu_pkg::SUM_W'(req2_ff.bx);
      be[1] = v3alu_pkg::SUM_W'(req2_ff.by);
      be[2] = v3alu_pkg::SUM_W'(req2_ff.bz);
      for (int l = 0; l < v3alu_pkg::LANES; l++) begin
         diff[l]  = ae[l] - be[l];
         absd[l]  = diff[l][v3alu_pkg::SUM_W-1] ? -diff[l] : diff[l];
         close[l] = absd[l] <= {{(v3alu_pkg::SUM_W-v3alu_pkg::TOL_W){1'b0}}, tol};
      end
   end

   // Combine per operation, then saturate once per value.
   always_comb begin
      for (int l = 0; l < v3alu_pkg::LANES; l++) begin
         vsum[l] = '0;
      end
      ssum = '0;
      eq   = 1'b0;
      unique case (v3alu_pkg::kind_type'(req2_ff.kind))
         v3alu_pkg::KIND_ADD: begin
            for (int l = 0; l < v3alu_pkg::LANES; l++) vsum[l] = ae[l] + be[l];
         end
         v3alu_pkg::KIND_SUB: begin
            for (int l = 0; l < v3alu_pkg::LANES; l++) vsum[l] = ae[l] - be[l];
         end
         v3alu_pkg::KIND_CROSS: begin
            vsum[0] = qe[0] - qe[1];
            vsum[1] = qe[2] - qe[3];
            vsum[2] = qe[4] - qe[5];
         end
         v3alu_pkg::KIND_MULADD: begin
            for (int l = 0; l < v3alu_pkg::LANES; l++) vsum[l] = ae[l] + qe[l];
         end
         v3alu_pkg::KIND_SCALE: begin
            for (int l = 0; l < v3alu_pkg::LANES; l++) vsum[l] = qe[l];
         end
         v3alu_pkg::KIND_NEGATE: begin
            for (int l = 0; l < v3alu_pkg::LANES; l++) vsum[l] = -ae[l];
         end
         v3alu_pkg::KIND_DOT: begin
            ssum = qe[0] + qe[1] + qe[2];
         end
         v3alu_pkg::KIND_EXACT_EQ: begin
            eq = (ae[0] == be[0]) && (ae[1] == be[1]) && (ae[2] == be[2]);
         end
         v3alu_pkg::KIND_APPROX_EQ: begin
            eq = &close;
         end
         default: begin
         end
      endcase
      for (int l = 0; l < v3alu_pkg::LANES; l++) begin
         vsat[l] = v3alu_pkg::sat32(vsum[l]);
      end
      ssat = v3alu_pkg::sat32(ssum);

      mid_in.kind    = v3alu_pkg::kind_type'(req2_ff.kind);
      mid_in.avec[0] = req2_ff.ax;
      mid_in.avec[1] = req2_ff.ay;
      mid_in.avec[2] = req2_ff.az;
      mid_in.sq      = prod_ff[0] + prod_ff[1] + prod_ff[2];
      mid_in.res.rx            = vsat[0].val;
      mid_in.res.ry            = vsat[1].val;
      mid_in.res.rz            = vsat[2].val;
      mid_in.res.scalar_result = ssat.val;
      mid_in.res.equal_flag    = eq;
      mid_in.res.overflow      = vsat[0].ovf | vsat[1].ovf | vsat[2].ovf | ssat.ovf;
   end

   // Payload registers: input capture, products, combined result.
   always_ff @(posedge clock) begin
      if (advance) begin
         req1_ff <= in_req;
         req2_ff <= req1_ff;
         mid_ff  <= mid_in;
         for (int l = 0; l < v3alu_pkg::MUL_LANES; l++) begin
            prod_ff[l] <= prod_in[l];
         end
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_mid   = mid_ff;

endmodule

// ----- rtl/v3alu_norm.sv -----
`timescale 1ns / 1ps
module v3alu_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  v3alu_pkg::mid_type    in_mid,
   output logic                  out_valid,
   output v3alu_pkg::rsp_type    out_rsp
);

   v3alu_pkg::root_type                 root_src [v3alu_pkg::ROOT_STEPS];
   v3alu_pkg::root_type                 root_in  [v3alu_pkg::ROOT_STEPS];
   v3alu_pkg::root_type                 root_ff  [v3alu_pkg::ROOT_STEPS];
   logic [v3alu_pkg::PROD_W-1:0]        trial    [v3alu_pkg::ROOT_STEPS];
   logic [v3alu_pkg::ROOT_STEPS-1:0]    rv_src;
   logic [v3alu_pkg::ROOT_STEPS-1:0]    rv_ff;

   v3alu_pkg::div_type                  setup_in;
   v3alu_pkg::div_type                  setup_ff;
   logic                                sv_ff;
   logic [v3alu_pkg::DATA_W-1:0]        mag [v3alu_pkg::LANES];

   v3alu_pkg::div_type                  div_src [v3alu_pkg::QUO_W];
   v3alu_pkg::div_type                  div_in  [v3alu_pkg::QUO_W];
   v3alu_pkg::div_type                  div_ff  [v3alu_pkg::QUO_W];
   logic [v3alu_pkg::QUO_W-1:0]         dv_src;
   logic [v3alu_pkg::QUO_W-1:0]         dv_ff;

   v3alu_pkg::div_type                  last;
   logic [v3alu_pkg::DATA_W-1:0]        comp [v3alu_pkg::LANES];
   logic [v3alu_pkg::DATA_W-1:0]        qext [v3alu_pkg::LANES];
   v3alu_pkg::rsp_type                  out_in;
   v3alu_pkg::rsp_type                  out_ff;
   logic                                ov_ff;

   // Load the square-root chain from the front end.
   always_comb begin
      root_src[0].kind = in_mid.kind;
      root_src[0].avec = in_mid.avec;
      root_src[0].res  = in_mid.res;
      root_src[0].n    = in_mid.sq;
      root_src[0].r    = '0;
      rv_src[0]        = in_valid;
      for (int i = 1; i < v3alu_pkg::ROOT_STEPS; i++) begin
         root_src[i] = root_ff[i-1];
         rv_src[i]   = rv_ff[i-1];
      end
   end

   // One bit of the integer square root per stage.
   for (genvar i = 0; i < v3alu_pkg::ROOT_STEPS; i++) begin : g_root
      localparam logic [v3alu_pkg::PROD_W-1:0] BIT =
         v3alu_pkg::PROD_W'(1) << (v3alu_pkg::PROD_W - 2 - 2 * i);

      assign trial[i] = root_src[i].r + BIT;

      always_comb begin
         root_in[i] = root_src[i];
         if (root_src[i].n >= trial[i]) begin
            root_in[i].n = root_src[i].n - trial[i];
            root_in[i].r = (root_src[i].r >> 1) + BIT;
         end else begin
            root_in[i].r = root_src[i].r >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            root_ff[i] <= root_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[i] <= 1'b0;
         end else if (advance) begin
            rv_ff[i] <= rv_src[i];
         end
      end
   end

   // Length result and divider setup: magnitudes shifted into the fraction.
   always_comb begin
      setup_in.kind = root_ff[v3alu_pkg::ROOT_STEPS-1].kind;
      setup_in.avec = root_ff[v3alu_pkg::ROOT_STEPS-1].avec;
      setup_in.res  = root_ff[v3alu_pkg::ROOT_STEPS-1].res;
      setup_in.len  = root_ff[v3alu_pkg::ROOT_STEPS-1].r[v3alu_pkg::DATA_W-1:0];
      setup_in.quo  = '0;
      for (int l = 0; l < v3alu_pkg::LANES; l++) begin
         mag[l] = setup_in.avec[l][v3alu_pkg::DATA_W-1] ? -setup_in.avec[l]
                                                        : setup_in.avec[l];
         setup_in.rem[l] = {mag[l], {v3alu_pkg::FRAC_W{1'b0}}};
      end
      if (setup_in.kind == v3alu_pkg::KIND_LENGTH ||
          setup_in.kind == v3alu_pkg::KIND_NORMALIZE) begin
         setup_in.res.overflow      = setup_in.len[v3alu_pkg::DATA_W-1];
         setup_in.res.scalar_result = setup_in.len[v3alu_pkg::DATA_W-1]
                                      ? {1'b0, {(v3alu_pkg::DATA_W-1){1'b1}}}
                                      : setup_in.len;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         setup_ff <= setup_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
      end else if (advance) begin
         sv_ff <= rv_ff[v3alu_pkg::ROOT_STEPS-1];
      end
   end

   always_comb begin
      div_src[0] = setup_ff;
      dv_src[0]  = sv_ff;
      for (int j = 1; j < v3alu_pkg::QUO_W; j++) begin
         div_src[j] = div_ff[j-1];
         dv_src[j]  = dv_ff[j-1];
      end
   end

   // Restoring division, one quotient bit per stage, three lanes side by side.
   for (genvar j = 0; j < v3alu_pkg::QUO_W; j++) begin : g_div
      localparam int unsigned K = v3alu_pkg::QUO_W - 1 - j;

      logic [v3alu_pkg::REM_W-1:0] dvs;
      assign dvs = v3alu_pkg::REM_W'(div_src[j].len) << K;

      always_comb begin
         div_in[j] = div_src[j];
         for (int l = 0; l < v3alu_pkg::LANES; l++) begin
            if (div_src[j].rem[l] >= dvs) begin
               div_in[j].rem[l]    = div_src[j].rem[l] - dvs;
               div_in[j].quo[l][K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[j] <= div_in[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (advance) begin
            dv_ff[j] <= dv_src[j];
         end
      end
   end

   // Apply signs; a zero length passes A through.
   always_comb begin
      last   = div_ff[v3alu_pkg::QUO_W-1];
      out_in = last.res;
      for (int l = 0; l < v3alu_pkg::LANES; l++) begin
         qext[l] = v3alu_pkg::DATA_W'(last.quo[l]);
         if (last.len == '0) begin
            comp[l] = last.avec[l];
         end else if (last.avec[l][v3alu_pkg::DATA_W-1]) begin
            comp[l] = -qext[l];
         end else begin
            comp[l] = qext[l];
         end
      end
      if (last.kind == v3alu_pkg::KIND_NORMALIZE) begin
         out_in.rx = comp[0];
         out_in.ry = comp[1];
         out_in.rz = comp[2];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (advance) begin
         ov_ff <= dv_ff[v3alu_pkg::QUO_W-1];
      end
   end

   assign out_valid = ov_ff;
   assign out_rsp   = out_ff;

endmodule

// ----- rtl/vec3_vector_alu.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_data (opcode, A, B, factor)
// rsp       out        rsp_valid/rsp_stall   rsp_data (vector, scalar, flags)
// csr       in         csr_valid/csr_ready   csr_data (equal tolerance)
//
// One request enters per cycle while no stalled result holds the pipeline.
// The pipeline holds a 32-stage square-root chain and a 17-stage divider.
// A stalled result freezes the whole pipeline and stalls the request side with it.
// Synchronous reset empties the pipeline and sets the tolerance to 7.
`include "vec3_vector_alu_defines.svh"
module vec3_vector_alu (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  v3alu_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output v3alu_pkg::rsp_type            rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [v3alu_pkg::TOL_W-1:0]   csr_data
);

   logic                           advance;
   logic                           mid_valid;
   v3alu_pkg::mid_type             mid;
   logic [v3alu_pkg::TOL_W-1:0]    tol_ff;

   // The pipeline moves whenever the output register is free or being taken.
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // Tolerance register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= v3alu_pkg::TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   v3alu_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_req    (req_data),
      .tol       (tol_ff),
      .out_valid (mid_valid),
      .out_mid   (mid)
   );

   v3alu_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (mid_valid),
      .in_mid    (mid),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

   // Checks on the pipeline control and result encoding.
   `V3A_IMPLY(a_backpressure, rsp_valid && rsp_stall, req_stall, "stall did not reach input")
   `V3A_IMPLY(a_eq_no_ovf, rsp_valid && rsp_data.equal_flag, !rsp_data.overflow, "eq with ovf")
   `V3A_AFTER_RESET(a_reset_empty, !rsp_valid, "result valid right after reset")

endmodule

// ----- bench/vec3_vector_alu_tb.sv -----
`timescale 1ns / 1ps
module vec3_vector_alu_tb;
   import v3alu_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 60;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [TOL_W-1:0]     csr_data = '0;

   // Shadow copy of the tolerance register and the results still owed by the unit.
   logic [TOL_W-1:0]     tolerance = TOL_RESET;
   rsp_type              pending_results[$];
   int                   error_count = 0;
   int                   idle_cycles = 0;
   int                   burst_left = 0;
   bit                   gaps_on = 1'b1;
   int                   hold_left = 0;
   int                   pattern_left = 0;
   int                   stall_percent = 0;

   vec3_vector_alu i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   // Clamp a wide value to a 32-bit word and note any saturation.
   function automatic word_type clamp_word(input longint value, inout bit ovf);
      if (value > 64'sd2147483647) begin
         ovf = 1'b1;
         return 32'h7fffffff;
      end
      if (value < -64'sd2147483648) begin
         ovf = 1'b1;
         return 32'h80000000;
      end
      return value[31:0];
   endfunction

   // Computes the result the unit must give for one request.
   function automatic rsp_type predict_result(input req_type rq, input logic [TOL_W-1:0] tol);
      longint            a[3];
      longint            b[3];
      longint            v[3];
      longint            f;
      longint            s;
      longint            d;
      longint unsigned   sq;
      longint unsigned   len;
      longint unsigned   rem;
      longint unsigned   bitv;
      longint unsigned   m;
      longint unsigned   q;
      bit                ovf;
      bit                eq;
      bit                vec;
      bit                has_s;
      rsp_type           r;
      a[0] = rq.ax; a[1] = rq.ay; a[2] = rq.az;
      b[0] = rq.bx; b[1] = rq.by; b[2] = rq.bz;
      f = rq.factor;
      v[0] = 0; v[1] = 0; v[2] = 0;
      s = 0; ovf = 0; eq = 0; vec = 0; has_s = 0;
      // Products drop 16 fraction bits, which is an arithmetic shift.
      case (rq.kind)
         KIND_ADD: begin
            for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
            vec = 1;
         end
         KIND_SUB: begin
            for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
            vec = 1;
         end
         KIND_CROSS: begin
            v[0] = ((a[1] * b[2]) >>> 16) - ((a[2] * b[1]) >>> 16);
            v[1] = ((a[2] * b[0]) >>> 16) - ((a[0] * b[2]) >>> 16);
            v[2] = ((a[0] * b[1]) >>> 16) - ((a[1] * b[0]) >>> 16);
            vec = 1;
         end
         KIND_MULADD: begin
            for (int i = 0; i < 3; i++) v[i] = a[i] + ((f * b[i]) >>> 16);
            vec = 1;
         end
         KIND_SCALE: begin
            for (int i = 0; i < 3; i++) v[i] = (a[i] * f) >>> 16;
            vec = 1;
         end
         KIND_NEGATE: begin
            for (int i = 0; i < 3; i++) v[i] = -a[i];
            vec = 1;
         end
         KIND_DOT: begin
            s = ((a[0] * b[0]) >>> 16) + ((a[1] * b[1]) >>> 16) + ((a[2] * b[2]) >>> 16);
            has_s = 1;
         end
         KIND_LENGTH, KIND_NORMALIZE: begin
            sq = 0;
            for (int i = 0; i < 3; i++) sq += longint'(a[i] * a[i]);
            // Bitwise floor square root.
            rem = sq;
            len = 0;
            bitv = 64'd1 << 62;
            while (bitv > rem) bitv >>= 2;
            while (bitv != 0) begin
               if (rem >= len + bitv) begin
                  rem -= len + bitv;
                  len = (len >> 1) + bitv;
               end else begin
                  len >>= 1;
               end
               bitv >>= 2;
            end
            s = longint'(len);
            has_s = 1;
            if (rq.kind == KIND_NORMALIZE) begin
               vec = 1;
               // A zero vector passes through; otherwise divide, truncating toward zero.
               for (int i = 0; i < 3; i++) begin
                  if (len == 0) begin
                     v[i] = a[i];
                  end else begin
                     m = (a[i] < 0) ? longint'(-a[i]) : longint'(a[i]);
                     q = (m << 16) / len;
                     v[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
                  end
               end
            end
         end
         KIND_EXACT_EQ: begin
            eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
         end
         KIND_APPROX_EQ: begin
            eq = 1;
            for (int i = 0; i < 3; i++) begin
               d = a[i] - b[i];
               if (d < 0) d = -d;
               if (d > longint'(tol)) eq = 0;
            end
         end
         default: begin
         end
      endcase
      r = '0;
      if (vec) begin
         r.rx = clamp_word(v[0], ovf);
         r.ry = clamp_word(v[1], ovf);
         r.rz = clamp_word(v[2], ovf);
      end
      if (has_s) r.scalar_result = clamp_word(s, ovf);
      r.equal_flag = eq;
      r.overflow = ovf;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch in %s: got %h, expected %h", $realtime, field, got, want);
      error_count++;
   endtask

   // Checks each accepted result against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with no request outstanding", $realtime);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.rx !== want.rx) report_mismatch("rx", rsp_data.rx, want.rx);
            if (rsp_data.ry !== want.ry) report_mismatch("ry", rsp_data.ry, want.ry);
            if (rsp_data.rz !== want.rz) report_mismatch("rz", rsp_data.rz, want.rz);
            if (rsp_data.scalar_result !== want.scalar_result)
               report_mismatch("scalar_result", rsp_data.scalar_result, want.scalar_result);
            if (rsp_data.equal_flag !== want.equal_flag)
               report_mismatch("equal_flag", rsp_data.equal_flag, want.equal_flag);
            if (rsp_data.overflow !== want.overflow)
               report_mismatch("overflow", rsp_data.overflow, want.overflow);
         end
      end
   end

   // Receiver: a forced hold-off when asked, else stall rates that change now and then.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
               0: stall_percent = 0;
               1: stall_percent = 20;
               2: stall_percent = 50;
               default: stall_percent = 85;
            endcase
         end
         pattern_left = pattern_left - 1;
         rsp_stall <= ($urandom_range(0, 99) < stall_percent);
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
         $display("[vec3_vector_alu] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one request, with burst gaps while they are on, and records its expected result on acceptance.
   task automatic send_request(input req_type rq);
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(predict_result(rq, tolerance));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TOL_W-1:0] value);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tolerance = value;
      csr_valid <= 1'b0;
   endtask

   function automatic word_type random_word();
      case ($urandom_range(0, 7))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
         3, 4: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_request(input logic [3:0] kind, input word_type ax,
                                            input word_type ay, input word_type az,
                                            input word_type bx, input word_type by,
                                            input word_type bz, input word_type factor);
      req_type rq;
      rq.kind = kind;
      rq.ax = ax; rq.ay = ay; rq.az = az;
      rq.bx = bx; rq.by = by; rq.bz = bz;
      rq.factor = factor;
      return rq;
   endfunction

   // Random request: mostly valid operations, shaped so equality and zero cases occur.
   function automatic req_type random_request();
      req_type rq;
      rq.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(0, 10));
      rq.ax = random_word(); rq.ay = random_word(); rq.az = random_word();
      rq.bx = random_word(); rq.by = random_word(); rq.bz = random_word();
      rq.factor = random_word();
      case ($urandom_range(0, 5))
         0: begin
            rq.bx = rq.ax + $signed($urandom_range(0, 20)) - 10;
            rq.by = rq.ay + $signed($urandom_range(0, 20)) - 10;
            rq.bz = rq.az + $signed($urandom_range(0, 20)) - 10;
         end
         1: begin
            rq.bx = rq.ax; rq.by = rq.ay; rq.bz = rq.az;
         end
         2: begin
            rq.bx = '0; rq.by = '0; rq.bz = '0;
            if ($urandom_range(0, 1)) begin
               rq.ax = '0; rq.ay = '0; rq.az = '0;
            end
         end
         default: begin
         end
      endcase
      return rq;
   endfunction

   // Every operation at field extremes, plus saturation, zero-length, zero and unused-opcode tests.
   task automatic test_directed();
      word_type mx;
      word_type mn;
      word_type one;
      mx = 32'h7fffffff;
      mn = 32'h80000000;
      one = 32'h00010000;
      send_request(make_request(KIND_ADD, mx, mn, one, mx, mn, -one, '0));
      send_request(make_request(KIND_SUB, mn, mx, '0, mx, mn, one, '0));
      send_request(make_request(KIND_CROSS, mx, mn, mx, mn, mx, mn, '0));
      send_request(make_request(KIND_CROSS, one, '0, '0, '0, one, '0, '0));
      send_request(make_request(KIND_MULADD, mx, mn, one, mx, mx, mn, mn));
      send_request(make_request(KIND_MULADD, one, one, one, -one, one, 3, -one));
      send_request(make_request(KIND_SCALE, mn, mx, -1, mn, '0, '0, mn));
      send_request(make_request(KIND_SCALE, -3, 5, -one, '0, '0, '0, 32'h00008000));
      send_request(make_request(KIND_NEGATE, mn, mx, '0, '0, '0, '0, '0));
      send_request(make_request(KIND_DOT, mx, mx, mx, mx, mx, mx, '0));
      send_request(make_request(KIND_DOT, mn, one, -1, mx, -one, 1, '0));
      send_request(make_request(KIND_LENGTH, mn, mn, mn, '0, '0, '0, '0));
      send_request(make_request(KIND_LENGTH, 32'h00030000, 32'h00040000, '0, '0, '0, '0, '0));
      send_request(make_request(KIND_NORMALIZE, mn, mx, mn, '0, '0, '0, '0));
      send_request(make_request(KIND_NORMALIZE, '0, '0, '0, mx, '0, '0, '0));
      send_request(make_request(KIND_NORMALIZE, -1, '0, '0, '0, '0, '0, '0));
      send_request(make_request(KIND_EXACT_EQ, mn, mx, '0, mn, mx, '0, '0));
      send_request(make_request(KIND_EXACT_EQ, '0, '0, '0, '0, '0, '0, '0));
      send_request(make_request(KIND_EXACT_EQ, '0, '0, 1, '0, '0, '0, '0));
      send_request(make_request(KIND_APPROX_EQ, 7, -7, '0, '0, '0, '0, '0));
      send_request(make_request(KIND_APPROX_EQ, 8, '0, '0, '0, '0, '0, '0));
      send_request(make_request(KIND_APPROX_EQ, mx, '0, '0, mn, '0, '0, '0));
      send_request(make_request(4'd11, mx, mx, mx, mx, mx, mx, mx));
      send_request(make_request(4'd15, mn, mn, mn, mn, mn, mn, mn));
   endtask

   // Tolerance extremes and random settings, each with equality checks around it.
   task automatic test_tolerance();
      logic [TOL_W-1:0] settings[5];
      settings[0] = '0;
      settings[1] = '1;
      settings[2] = 31'd1;
      settings[3] = TOL_W'($urandom);
      settings[4] = TOL_W'($urandom_range(0, 32'h0000ffff));
      foreach (settings[k]) begin
         write_tolerance(settings[k]);
         repeat (40) begin
            req_type rq;
            rq = random_request();
            rq.kind = KIND_APPROX_EQ;
            if ($urandom_range(0, 1)) begin
               // The tolerance is unsigned, so it is widened with a zero sign bit.
               rq.bx = rq.ax + word_type'({1'b0, settings[k]});
               rq.by = rq.ay - word_type'({1'b0, settings[k]}) +
                       $signed($urandom_range(0, 1));
            end
            send_request(rq);
         end
      end
   endtask

   // Long receiver hold-off while requests keep coming, so the input side must stall.
   task automatic test_backpressure();
      gaps_on = 1'b0;
      hold_left = 300;
      repeat (100) send_request(random_request());
      gaps_on = 1'b1;
      wait_for_results();
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) begin
         // Some stretches run without sender gaps.
         if (n % 200 == 0) gaps_on = $urandom_range(0, 2) != 0;
         send_request(random_request());
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_tolerance();
      test_backpressure();
      test_random(700);
      wait_for_results();
      write_tolerance(31'd7);
      test_random(700);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[vec3_vector_alu] OK");
      end else begin
         $display("[vec3_vector_alu] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/v3alu_pkg.sv
rtl/v3alu_arith.sv
rtl/v3alu_norm.sv
rtl/vec3_vector_alu.sv
bench/vec3_vector_alu_tb.sv
